// File: rtl/core/digit_hamming_distance_assert.svh
// Assertion macros used by the checker file of the digit Hamming distance block.
`ifndef DIGIT_HAMMING_DISTANCE_ASSERT_SVH
`define DIGIT_HAMMING_DISTANCE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DHD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("digit_hamming_distance: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DHD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("digit_hamming_distance: assertion failed");

`endif

// File: rtl/core/dhd_pkg.sv
`timescale 1ns / 1ps

package dhd_pkg;

  localparam int BASE_W = 32;
  localparam int DIST_W = 6;
  localparam int DIST_MAX = 63;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_A,
    ST_DIV_B,
    ST_FINISH
  } state_e;

endpackage

// File: rtl/core/digit_hamming_distance.sv
`timescale 1ns / 1ps

// Digit Hamming distance of two unsigned operands in a programmable radix.
// Input channel: in_valid_i / in_stall_o with first_number_i and second_number_i.
// A transfer happens on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with digit_distance_o, held in an
// output register until its transfer completes.
// Configuration: digit_base_i is written when digit_base_we_i is high; a base
// below two acts as base two. Write it only while the block is idle.
// One item at a time: a single restoring divider, one quotient bit per cycle,
// divides the first and then the second operand by the base for each digit.
// The input is stalled during this work. A new item is taken while the previous
// result still waits in the output register, but its result is not written
// until that register has been emptied.
// Reset returns the base to ten, empties the output register and idles the block.
module digit_hamming_distance
  import dhd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  digit_base_we_i,
  input  logic [BASE_W-1:0]     digit_base_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] first_number_i,
  input  logic [DATA_WIDTH-1:0] second_number_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DIST_W-1:0]     digit_distance_o
);

  localparam int CntW = $clog2(DATA_WIDTH);
  localparam int DigW = $clog2(DATA_WIDTH + 1);
  localparam int DistLimit = (DATA_WIDTH < DIST_MAX) ? DATA_WIDTH : DIST_MAX;

  state_e state_q, state_d;

  logic [BASE_W-1:0]     base_q;
  logic [DATA_WIDTH-1:0] a_q, b_q, quot_a_q;
  logic [BASE_W-1:0]     rem_a_q;
  logic [DATA_WIDTH-1:0] div_num_q, div_num_d;
  logic [BASE_W-1:0]     div_rem_q, div_rem_d;
  logic [CntW-1:0]       bit_cnt_q;
  logic [DigW-1:0]       dist_cnt_q;
  logic [DIST_W-1:0]     dist_out_q;
  logic                  out_valid_q;

  logic [BASE_W:0] trial;
  logic [BASE_W:0] trial_sub;
  logic            trial_ge;
  logic            bit_last;
  logic            ops_zero;
  logic            out_free;
  logic            digit_diff;
  logic            load_item;
  logic            start_div;
  logic            write_out;

  // Shared restoring divider step.
  assign trial     = {div_rem_q, div_num_q[DATA_WIDTH-1]};
  assign trial_sub = trial - {1'b0, base_q};
  assign trial_ge  = trial >= {1'b0, base_q};
  assign div_rem_d = trial_ge ? trial_sub[BASE_W-1:0] : trial[BASE_W-1:0];
  assign div_num_d = {div_num_q[DATA_WIDTH-2:0], trial_ge};
  assign bit_last  = (bit_cnt_q == CntW'(DATA_WIDTH - 1));

  assign ops_zero   = (a_q == '0) && (b_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign digit_diff = ((a_q != '0) != (b_q != '0)) || (div_rem_d != rem_a_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = ops_zero ? ST_FINISH : ST_DIV_A;
      end
      ST_DIV_A: begin
        if (bit_last) state_d = ST_DIV_B;
      end
      ST_DIV_B: begin
        if (bit_last) state_d = ST_CHECK;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_item  = 1'b0;
    start_div  = 1'b0;
    write_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        load_item  = in_valid_i;
      end
      ST_CHECK: begin
        start_div = !ops_zero;
      end
      ST_FINISH: begin
        write_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= BASE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (digit_base_we_i) begin
        base_q <= (digit_base_i < BASE_MIN) ? BASE_MIN : digit_base_i;
      end
      if (write_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      a_q        <= first_number_i;
      b_q        <= second_number_i;
      dist_cnt_q <= '0;
    end
    if (start_div) begin
      div_num_q <= a_q;
      div_rem_q <= '0;
      bit_cnt_q <= '0;
    end
    if (state_q == ST_DIV_A) begin
      if (bit_last) begin
        quot_a_q  <= div_num_d;
        rem_a_q   <= div_rem_d;
        div_num_q <= b_q;
        div_rem_q <= '0;
        bit_cnt_q <= '0;
      end else begin
        div_num_q <= div_num_d;
        div_rem_q <= div_rem_d;
        bit_cnt_q <= bit_cnt_q + CntW'(1);
      end
    end
    if (state_q == ST_DIV_B) begin
      div_num_q <= div_num_d;
      div_rem_q <= div_rem_d;
      bit_cnt_q <= bit_cnt_q + CntW'(1);
      if (bit_last) begin
        a_q <= quot_a_q;
        b_q <= div_num_d;
        if (digit_diff) dist_cnt_q <= dist_cnt_q + DigW'(1);
      end
    end
    if (write_out) begin
      if (dist_cnt_q > DigW'(DistLimit)) begin
        dist_out_q <= DIST_W'(DistLimit);
      end else begin
        dist_out_q <= DIST_W'(dist_cnt_q);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign digit_distance_o = dist_out_q;

endmodule

// File: rtl/core/dhd_checker.sv
`timescale 1ns / 1ps

`include "digit_hamming_distance_assert.svh"

module dhd_checker
  import dhd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  digit_base_we_i,
  input logic [BASE_W-1:0]     digit_base_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [DATA_WIDTH-1:0] first_number_i,
  input logic [DATA_WIDTH-1:0] second_number_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DIST_W-1:0]     digit_distance_o
);

  localparam int DistLimit = (DATA_WIDTH < DIST_MAX) ? DATA_WIDTH : DIST_MAX;

  // A result waiting on a stalled receiver keeps its value.
  `DHD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(digit_distance_o))

  // The distance never exceeds the number of digits an operand can have.
  `DHD_ASSERT_NOW(a_dist_range, clk_i, rst_ni, out_valid_o,
                  digit_distance_o <= DIST_W'(DistLimit))

  // After an input transfer the block is busy with that item.
  `DHD_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result appears exactly when the block returns to idle.
  `DHD_ASSERT_NOW(a_idle_on_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

endmodule

bind digit_hamming_distance dhd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dhd_checker (.*);

// File: sim/digit_hamming_distance_tb.sv
`timescale 1ns / 1ps

module digit_hamming_distance_tb;
  import dhd_pkg::*;

  localparam int DATA_WIDTH = 32;
  localparam int PROBE_N = 24;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 46;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 50;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    logic [BASE_W-1:0]     radix;
    logic [DATA_WIDTH-1:0] lhs;
    logic [DATA_WIDTH-1:0] rhs;
    logic                  known;
    logic [DIST_W-1:0]     distance;
  } probe_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  digit_base_we_i = 1'b0;
  logic [BASE_W-1:0]     digit_base_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [DATA_WIDTH-1:0] first_number_i = '0;
  logic [DATA_WIDTH-1:0] second_number_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [DIST_W-1:0]     digit_distance_o;

  logic [DIST_W-1:0] pending_distances [$];
  logic [DIST_W-1:0] wanted_distance;
  logic [BASE_W-1:0] radix_now;
  bit                calm = 1'b0;
  bit                rx_armed = 1'b0;
  int                rx_hold = 0;
  int                error_count = 0;
  int                cycle_count = 0;

  probe_t probes [0:PROBE_N-1] = '{
    '{32'd10, 32'd0, 32'd0, 1'b1, 6'd0},
    '{32'd10, 32'd0, 32'd5, 1'b1, 6'd1},
    '{32'd10, 32'd7, 32'd7, 1'b1, 6'd0},
    '{32'd10, 32'd123, 32'd124, 1'b1, 6'd1},
    '{32'd10, 32'd1000, 32'd1, 1'b1, 6'd4},
    '{32'd10, 32'd5, 32'd15, 1'b1, 6'd1},
    '{32'd10, 32'hFFFF_FFFF, 32'd0, 1'b1, 6'd10},
    '{32'd10, 32'd0, 32'hFFFF_FFFF, 1'b1, 6'd10},
    '{32'd10, 32'd1234567890, 32'd987654321, 1'b1, 6'd10},
    '{32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd0},
    '{32'd10, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 6'd0},
    '{32'd2, 32'hFFFF_FFFF, 32'd0, 1'b1, 6'd32},
    '{32'd2, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 6'd32},
    '{32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 6'd32},
    '{32'd2, 32'd1, 32'd3, 1'b1, 6'd1},
    '{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 6'd32},
    '{32'd0, 32'd6, 32'd5, 1'b0, 6'd0},
    '{32'd1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 6'd32},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 1'b1, 6'd1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, 1'b1, 6'd1},
    '{32'hFFFF_FFFF, 32'd12345, 32'd12345, 1'b1, 6'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 6'd0},
    '{32'd16, 32'hDEAD_BEEF, 32'hDE5D_BEE0, 1'b0, 6'd0},
    '{32'd16, 32'd0, 32'd0, 1'b1, 6'd0}
  };

  digit_hamming_distance #(
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .digit_base_we_i (digit_base_we_i),
    .digit_base_i    (digit_base_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_number_i  (first_number_i),
    .second_number_i (second_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digit_distance_o(digit_distance_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [DIST_W-1:0] digit_distance_of(input logic [DATA_WIDTH-1:0] lhs,
                                                          input logic [DATA_WIDTH-1:0] rhs,
                                                          input logic [BASE_W-1:0] radix_in);
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
    logic [BASE_W-1:0]     radix;
    int                    differ;
    int                    digit_idx;
    x = lhs;
    y = rhs;
    radix = (radix_in < BASE_MIN) ? BASE_MIN : radix_in;
    differ = 0;
    digit_idx = 0;
    while ((x != 0 || y != 0) && digit_idx < 64) begin
      if ((x != 0) != (y != 0)) begin
        differ++;
      end else if ((x % radix) != (y % radix)) begin
        differ++;
      end
      x = x / radix;
      y = y / radix;
      digit_idx++;
    end
    if (differ > DATA_WIDTH) differ = DATA_WIDTH;
    if (differ > DIST_MAX) differ = DIST_MAX;
    return DIST_W'(differ);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    int kind;
    int bits;
    kind = $urandom_range(0, 9);
    bits = $urandom_range(1, 12);
    case (kind)
      0: return '0;
      1, 2, 3, 4, 5: return $urandom & ((32'd1 << bits) - 32'd1);
      6, 7, 8: return $urandom >> $urandom_range(0, 31);
      default: return '1;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] partner_of(input logic [DATA_WIDTH-1:0] x);
    case ($urandom_range(0, 5))
      0: return x;
      1: return x ^ (32'd1 << $urandom_range(0, 31));
      2, 3: return pick_operand();
      4: return '0;
      default: return x + $urandom_range(1, 9);
    endcase
  endfunction

  task automatic send_pair(input logic [DATA_WIDTH-1:0] lhs, input logic [DATA_WIDTH-1:0] rhs,
                           input logic [DIST_W-1:0] distance);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_number_i <= lhs;
    second_number_i <= rhs;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pending_distances.push_back(distance);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_base(input logic [BASE_W-1:0] radix);
    @(negedge clk_i);
    digit_base_we_i <= 1'b1;
    digit_base_i <= radix;
    @(negedge clk_i);
    digit_base_we_i <= 1'b0;
    radix_now = radix;
  endtask

  always @(negedge clk_i) begin
    if (out_valid_o === 1'b1 && !rx_armed) begin
      rx_armed = 1'b1;
      rx_hold = calm ? 0 : $urandom_range(0, 3);
    end
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      rx_armed = 1'b0;
      if (pending_distances.size() == 0) begin
        $display("%0t: digit_distance expected none, got %0d", $time, digit_distance_o);
        error_count++;
      end else begin
        wanted_distance = pending_distances.pop_front();
        if (digit_distance_o !== wanted_distance) begin
          $display("%0t: digit_distance expected %0d, got %0d", $time, wanted_distance,
                   digit_distance_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
    logic [DATA_WIDTH-1:0] held;
    logic [BASE_W-1:0]     next_base;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    radix_now = BASE_RESET;

    for (int i = 0; i < PROBE_N; i++) begin
      if (probes[i].radix != radix_now) begin
        drain();
        load_base(probes[i].radix);
      end
      send_pair(probes[i].lhs, probes[i].rhs,
                probes[i].known ? probes[i].distance
                                : digit_distance_of(probes[i].lhs, probes[i].rhs, radix_now));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: next_base = 32'd10;
        1: next_base = 32'd2;
        2: next_base = 32'd3;
        3: next_base = 32'd0;
        4: next_base = 32'd16;
        5: next_base = 32'd1;
        6: next_base = 32'd7;
        7: next_base = 32'hFFFF_FFFF;
        8: next_base = 32'd1000;
        9: next_base = $urandom_range(2, 40);
        10: next_base = $urandom;
        default: next_base = 32'h8000_0000;
      endcase
      drain();
      load_base(next_base);
      calm = (phase % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == 20) drain();
        x = pick_operand();
        y = partner_of(x);
        if ($urandom_range(0, 1) == 1) begin
          held = x;
          x = y;
          y = held;
        end
        send_pair(x, y, digit_distance_of(x, y, radix_now));
      end
    end

    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dhd_pkg.sv
rtl/core/digit_hamming_distance.sv
rtl/core/dhd_checker.sv
sim/digit_hamming_distance_tb.sv
